@@ rtl/tofq_pkg.sv @@
// shared constants for the timestamp-ordered frame queue
package tofq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;

  localparam int TS_W    = 64;
  localparam int TAG_W   = 16;
  localparam int DELTA_W = 16;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ rtl/tofq_ram.sv @@
// generic single-write, single-read ram with registered read data
module tofq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/timestamp_ordered_frame_queue.sv @@
// Frame descriptors sit in one ram used as a ring, kept in timestamp order (ties keep arrival
// order); one command is taken at a time and gives one response. Query, an add to a full
// queue and pop or peek on an empty queue go straight to the response (response valid the
// cycle after acceptance); pop and peek of an entry pass through S_HRD and S_HEV first,
// since the head entry comes through the ram's registered read. An add walks the ring
// backward from the tail, one ram read and evaluate (S_RD, S_EV) per entry: first past every
// entry with a later timestamp, shifting each up by one, then back to the nearest cluster
// start; S_PUT then writes the new entry. A response stall holds the response until it is
// taken. Track queries are answered from an audio entry count held in a register.
module timestamp_ordered_frame_queue #(
  parameter int QUEUE_DEPTH = tofq_pkg::QUEUE_DEPTH,
  parameter int TAG_BITS    = tofq_pkg::TAG_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  logic [tofq_pkg::CMD_W-1:0]  command,
  input  logic [tofq_pkg::TS_W-1:0]   timestamp_ms,
  input  logic                        starts_cluster,
  input  logic                        track_kind,
  input  logic [tofq_pkg::TAG_W-1:0]  frame_tag,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [tofq_pkg::ST_W-1:0]   status,
  output logic [tofq_pkg::DELTA_W-1:0] delta_ms,
  output logic [tofq_pkg::TS_W-1:0]   head_timestamp_ms,
  output logic                        head_starts_cluster,
  output logic                        head_track,
  output logic [tofq_pkg::TAG_W-1:0]  head_tag,
  output logic                        track_found,
  output logic                        queue_empty
);

  localparam int IDXW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTW = tofq_pkg::TS_W + 2 + TAG_BITS;
  localparam int CLUS_BIT = TAG_BITS + 1;
  localparam int TRK_BIT  = TAG_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_HRD  = 3'd4;
  localparam logic [2:0] S_HEV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                         state;
  logic [CNTW-1:0]                    occupancy;
  logic [CNTW-1:0]                    audio_cnt;
  logic [IDXW-1:0]                    head;
  logic [tofq_pkg::TS_W-1:0]          cluster_base;
  logic [IDXW-1:0]                    hole;
  logic [IDXW-1:0]                    ptr;
  logic                               gov_search;
  logic [tofq_pkg::DELTA_W-1:0]       gov;
  logic [tofq_pkg::CMD_W-1:0]         cmd_q;
  logic [tofq_pkg::TS_W-1:0]          ts_q;
  logic                               clus_q;
  logic                               trk_q;
  logic [TAG_BITS-1:0]                tag_q;

  logic                               ram_we;
  logic [IDXW-1:0]                    ram_waddr;
  logic [ENTW-1:0]                    ram_wdata;
  logic [IDXW-1:0]                    ram_raddr;
  logic [ENTW-1:0]                    ram_rdata;
  logic [tofq_pkg::TS_W-1:0]          rd_time;
  logic                               rd_clus;
  logic                               rd_trk;
  logic [TAG_BITS-1:0]                rd_tag;
  logic                               later;

  // logical queue position to ring address
  function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] base,
                                           input logic [IDXW-1:0] lidx);
    logic [IDXW:0] sum;
    sum = {1'b0, base} + {1'b0, lidx};
    if (sum >= (IDXW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDXW+1)'(QUEUE_DEPTH);
    end
    return sum[IDXW-1:0];
  endfunction

  assign rd_time = ram_rdata[ENTW-1 -: tofq_pkg::TS_W];
  assign rd_clus = ram_rdata[CLUS_BIT];
  assign rd_trk  = ram_rdata[TRK_BIT];
  assign rd_tag  = ram_rdata[TAG_BITS-1:0];
  assign later   = ts_q < rd_time;

  assign cmd_stall   = (state != S_IDLE);
  assign rsp_valid   = (state == S_OUT);
  assign queue_empty = (occupancy == '0);

  // during the walk reads sit below the hole, so no read whose data is used overlaps a write to the same entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(head, hole);
    ram_wdata = {ts_q, clus_q, trk_q, tag_q};
    ram_raddr = phys(head, ptr);
    case (state)
      S_EV: begin
        if (!gov_search && later) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      S_PUT: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tofq_ram #(
    .WIDTH(ENTW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      occupancy    <= '0;
      audio_cnt    <= '0;
      head         <= '0;
      cluster_base <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q               <= command;
            ts_q                <= timestamp_ms;
            clus_q              <= starts_cluster;
            trk_q               <= track_kind;
            tag_q               <= TAG_BITS'(frame_tag);
            status              <= (command == tofq_pkg::CMD_ADD &&
                                    occupancy == CNTW'(QUEUE_DEPTH)) ? tofq_pkg::ST_FULL :
                                   ((command == tofq_pkg::CMD_POP ||
                                     command == tofq_pkg::CMD_PEEK) &&
                                    occupancy == '0) ? tofq_pkg::ST_EMPTY : tofq_pkg::ST_OK;
            delta_ms            <= '0;
            head_timestamp_ms   <= '0;
            head_starts_cluster <= 1'b0;
            head_track          <= 1'b0;
            head_tag            <= '0;
            track_found         <= (command == tofq_pkg::CMD_QUERY) &&
                                   (track_kind ? (audio_cnt != '0) : (audio_cnt != occupancy));
            gov_search          <= 1'b0;
            case (command)
              tofq_pkg::CMD_ADD: begin
                if (occupancy == CNTW'(QUEUE_DEPTH)) begin
                  state  <= S_OUT;
                end else begin
                  hole <= IDXW'(occupancy);
                  if (occupancy == '0) begin
                    gov   <= cluster_base[tofq_pkg::DELTA_W-1:0];
                    state <= S_PUT;
                  end else begin
                    ptr   <= IDXW'(occupancy - CNTW'(1));
                    state <= S_RD;
                  end
                end
              end
              tofq_pkg::CMD_POP, tofq_pkg::CMD_PEEK: begin
                if (occupancy == '0) begin
                  state  <= S_OUT;
                end else begin
                  ptr   <= '0;
                  state <= S_HRD;
                end
              end
              tofq_pkg::CMD_QUERY: begin
                state <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (!gov_search && later) begin
            // entry moved up into the hole, hole follows it down
            hole <= ptr;
            if (ptr == '0) begin
              gov   <= cluster_base[tofq_pkg::DELTA_W-1:0];
              state <= S_PUT;
            end else begin
              ptr   <= ptr - IDXW'(1);
              state <= S_RD;
            end
          end else begin
            // insertion point fixed, look back for the governing cluster start
            gov_search <= 1'b1;
            if (rd_clus) begin
              gov   <= rd_time[tofq_pkg::DELTA_W-1:0];
              state <= S_PUT;
            end else if (ptr == '0) begin
              gov   <= cluster_base[tofq_pkg::DELTA_W-1:0];
              state <= S_PUT;
            end else begin
              ptr   <= ptr - IDXW'(1);
              state <= S_RD;
            end
          end
        end
        S_PUT: begin
          occupancy <= occupancy + CNTW'(1);
          if (trk_q) begin
            audio_cnt <= audio_cnt + CNTW'(1);
          end
          delta_ms <= ts_q[tofq_pkg::DELTA_W-1:0] - gov;
          state    <= S_OUT;
        end
        S_HRD: begin
          state <= S_HEV;
        end
        S_HEV: begin
          head_timestamp_ms   <= rd_time;
          head_starts_cluster <= rd_clus;
          head_track          <= rd_trk;
          head_tag            <= tofq_pkg::TAG_W'(rd_tag);
          if (cmd_q == tofq_pkg::CMD_POP) begin
            if (rd_clus) begin
              cluster_base <= rd_time;
            end
            head      <= phys(head, IDXW'(1));
            occupancy <= occupancy - CNTW'(1);
            if (rd_trk) begin
              audio_cnt <= audio_cnt - CNTW'(1);
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/tofq_checker.sv @@
// port-level checks for the frame queue, bound to the top level
module tofq_port_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_stall,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic [tofq_pkg::ST_W-1:0]    status,
  input logic [tofq_pkg::DELTA_W-1:0] delta_ms,
  input logic [tofq_pkg::TS_W-1:0]    head_timestamp_ms,
  input logic                         head_starts_cluster,
  input logic                         head_track,
  input logic [tofq_pkg::TAG_W-1:0]   head_tag,
  input logic                         track_found,
  input logic                         queue_empty
);

  // stalled response keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(delta_ms)
      && $stable(head_timestamp_ms) && $stable(head_tag) && $stable(queue_empty))
    else $error("stalled response changed");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == tofq_pkg::ST_EMPTY |-> queue_empty && head_timestamp_ms == '0
      && !head_starts_cluster && !head_track && head_tag == '0)
    else $error("empty response with head data or nonempty queue");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == tofq_pkg::ST_FULL |-> delta_ms == '0 && !queue_empty
      && !track_found)
    else $error("full response inconsistent");

  // one command in flight: no new transaction while a response is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> cmd_stall)
    else $error("command accepted with response pending");

endmodule

bind timestamp_ordered_frame_queue tofq_port_checks u_tofq_port_checks (.*);

@@ test/tofq_checker.sv @@
// response predictor and checker for the timestamp-ordered frame queue
module tofq_checker
  import tofq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic                 cmd_stall,
  input  logic [CMD_W-1:0]     command,
  input  logic [TS_W-1:0]      timestamp_ms,
  input  logic                 starts_cluster,
  input  logic                 track_kind,
  input  logic [TAG_W-1:0]     frame_tag,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  logic [ST_W-1:0]      status,
  input  logic [DELTA_W-1:0]   delta_ms,
  input  logic [TS_W-1:0]      head_timestamp_ms,
  input  logic                 head_starts_cluster,
  input  logic                 head_track,
  input  logic [TAG_W-1:0]     head_tag,
  input  logic                 track_found,
  input  logic                 queue_empty,
  output int                   failures,
  output int                   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [DELTA_W-1:0] delta;
    logic [TS_W-1:0]    head_ts;
    logic               head_clus;
    logic               head_trk;
    logic [TAG_W-1:0]   head_tag;
    logic               found;
    logic               empty;
  } frame_response_t;

  frame_response_t  due_responses[$];

  // mirror of the sorted queue
  logic [TS_W-1:0]  slot_time [QUEUE_DEPTH];
  logic             slot_clus [QUEUE_DEPTH];
  logic             slot_trk  [QUEUE_DEPTH];
  logic [TAG_W-1:0] slot_tag  [QUEUE_DEPTH];
  int               fill;
  logic [TS_W-1:0]  cluster_base;

  function automatic frame_response_t apply_frame_command(
    input logic [CMD_W-1:0] cmd,
    input logic [TS_W-1:0]  ts,
    input logic             clus,
    input logic             trk,
    input logic [TAG_W-1:0] tag
  );
    frame_response_t r;
    logic [TS_W-1:0] gov;
    logic [TS_W-1:0] diff;
    int pos;
    bit hit;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        if (fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          gov = cluster_base;
          pos = fill;
          hit = 1'b0;
          // governing cluster is the last cluster start ahead of the insertion point
          for (int i = 0; i < fill; i++) begin
            if (!hit) begin
              if (ts < slot_time[i]) begin
                pos = i;
                hit = 1'b1;
              end else if (slot_clus[i]) begin
                gov = slot_time[i];
              end
            end
          end
          for (int i = fill; i > pos; i--) begin
            slot_time[i] = slot_time[i-1];
            slot_clus[i] = slot_clus[i-1];
            slot_trk[i]  = slot_trk[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_time[pos] = ts;
          slot_clus[pos] = clus;
          slot_trk[pos]  = trk;
          slot_tag[pos]  = tag & TAG_W'((64'd1 << TAG_BITS) - 64'd1);
          fill++;
          diff = ts - gov;
          r.status = ST_OK;
          r.delta = diff[DELTA_W-1:0];
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status    = ST_OK;
          r.head_ts   = slot_time[0];
          r.head_clus = slot_clus[0];
          r.head_trk  = slot_trk[0];
          r.head_tag  = slot_tag[0];
          if (cmd == CMD_POP) begin
            if (slot_clus[0]) cluster_base = slot_time[0];
            for (int i = 1; i < fill; i++) begin
              slot_time[i-1] = slot_time[i];
              slot_clus[i-1] = slot_clus[i];
              slot_trk[i-1]  = slot_trk[i];
              slot_tag[i-1]  = slot_tag[i];
            end
            fill--;
          end
        end
      end
      CMD_QUERY: begin
        r.status = ST_OK;
        for (int i = 0; i < fill; i++) begin
          if (slot_trk[i] == trk) r.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.empty = (fill == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_response_t want;
    if (rst) begin
      due_responses.delete();
      fill = 0;
      cluster_base = '0;
      failures = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        due_responses.push_back(apply_frame_command(command, timestamp_ms, starts_cluster,
                                                    track_kind, frame_tag));
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_responses.size() == 0) begin
          failures++;
          $display("%0t: response transaction with none due", $time);
        end else begin
          want = due_responses.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("delta_ms", 64'(want.delta), 64'(delta_ms));
          check_field("head_timestamp_ms", want.head_ts, head_timestamp_ms);
          check_field("head_starts_cluster", 64'(want.head_clus), 64'(head_starts_cluster));
          check_field("head_track", 64'(want.head_trk), 64'(head_track));
          check_field("head_tag", 64'(want.head_tag), 64'(head_tag));
          check_field("track_found", 64'(want.found), 64'(track_found));
          check_field("queue_empty", 64'(want.empty), 64'(queue_empty));
        end
      end
    end
    pending = due_responses.size();
  end

endmodule

@@ test/tb_timestamp_ordered_frame_queue.sv @@
// top-level testbench for the timestamp-ordered frame queue: stimulus and verdict
module tb_timestamp_ordered_frame_queue;
  import tofq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [CMD_W-1:0]   command = CMD_PEEK;
  logic [TS_W-1:0]    timestamp_ms = '0;
  logic               starts_cluster = 1'b0;
  logic               track_kind = 1'b0;
  logic [TAG_W-1:0]   frame_tag = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [ST_W-1:0]    status;
  logic [DELTA_W-1:0] delta_ms;
  logic [TS_W-1:0]    head_timestamp_ms;
  logic               head_starts_cluster;
  logic               head_track;
  logic [TAG_W-1:0]   head_tag;
  logic               track_found;
  logic               queue_empty;

  int cmd_idle_pct = 7;
  int rsp_idle_pct = 73;
  int mismatch_count;
  int responses_due;

  timestamp_ordered_frame_queue dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .timestamp_ms(timestamp_ms), .starts_cluster(starts_cluster),
    .track_kind(track_kind), .frame_tag(frame_tag),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .delta_ms(delta_ms), .head_timestamp_ms(head_timestamp_ms),
    .head_starts_cluster(head_starts_cluster), .head_track(head_track),
    .head_tag(head_tag), .track_found(track_found), .queue_empty(queue_empty)
  );

  tofq_checker u_checker (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .timestamp_ms(timestamp_ms), .starts_cluster(starts_cluster),
    .track_kind(track_kind), .frame_tag(frame_tag),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .delta_ms(delta_ms), .head_timestamp_ms(head_timestamp_ms),
    .head_starts_cluster(head_starts_cluster), .head_track(head_track),
    .head_tag(head_tag), .track_found(track_found), .queue_empty(queue_empty),
    .failures(mismatch_count), .pending(responses_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("timestamp_ordered_frame_queue regression: fail");
    $finish;
  end

  // returns once the transaction has been taken
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TS_W-1:0] ts,
                              input logic clus, input logic trk, input logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < cmd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid      <= 1'b1;
    command        <= cmd;
    timestamp_ms   <= ts;
    starts_cluster <= clus;
    track_kind     <= trk;
    frame_tag      <= tag;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  initial begin
    logic [TS_W-1:0]  ts_now;
    logic [TS_W-1:0]  ts_last;
    logic [TS_W-1:0]  ts;
    logic [CMD_W-1:0] cmd;
    int roll;
    int kind;
    bit filling;

    ts_now = 64'd100;
    ts_last = 64'd100;
    filling = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty queue
    send_command(CMD_PEEK, '0, 1'b0, 1'b0, '0);
    send_command(CMD_POP, '1, 1'b1, 1'b1, '1);
    send_command(CMD_QUERY, '0, 1'b0, 1'b0, '0);
    send_command(CMD_QUERY, '0, 1'b0, 1'b1, '0);
    // ordering, ties, field extremes
    send_command(CMD_ADD, 64'd1000, 1'b1, 1'b0, 16'h0000);
    send_command(CMD_ADD, 64'd0, 1'b0, 1'b1, 16'hffff);
    send_command(CMD_ADD, '1, 1'b1, 1'b1, 16'h1234);
    send_command(CMD_ADD, 64'd1000, 1'b0, 1'b0, 16'h0002);
    send_command(CMD_ADD, 64'd999, 1'b1, 1'b0, 16'h0003);
    send_command(CMD_QUERY, '0, 1'b0, 1'b0, '0);
    send_command(CMD_QUERY, '0, 1'b0, 1'b1, '0);
    send_command(CMD_PEEK, '0, 1'b0, 1'b0, '0);
    send_command(CMD_POP, '0, 1'b0, 1'b0, '0);
    send_command(CMD_POP, '0, 1'b0, 1'b0, '0);
    send_command(CMD_POP, '0, 1'b0, 1'b0, '0);
    // frame earlier than the cluster base wraps the delta
    send_command(CMD_ADD, 64'd500, 1'b0, 1'b1, 16'h0005);
    // fill to capacity, then one add too many
    for (int i = 0; i < QUEUE_DEPTH - 3; i++) begin
      send_command(CMD_ADD, 64'd2000 + 64'(i * 7), 1'(i % 3 == 0), 1'(i), 16'(i + 16));
    end
    send_command(CMD_ADD, 64'd3000, 1'b1, 1'b0, 16'h00aa);

    for (int phase = 0; phase < 3; phase++) begin
      cmd_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 73 : 0;
      rsp_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 7 : 0;
      for (int n = 0; n < 340; n++) begin
        // random fill or drain bursts so occupancy sweeps empty to full
        if (n % 40 == 0) filling = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (filling) begin
          cmd = (roll < 60) ? CMD_ADD : (roll < 80) ? CMD_POP : (roll < 90) ? CMD_PEEK : CMD_QUERY;
        end else begin
          cmd = (roll < 25) ? CMD_ADD : (roll < 75) ? CMD_POP : (roll < 88) ? CMD_PEEK : CMD_QUERY;
        end
        ts_now = ts_now + 64'($urandom_range(30));
        kind = $urandom_range(99);
        if (kind < 45) ts = ts_now + 64'($urandom_range(60)) - 64'd30;
        else if (kind < 65) ts = ts_last;
        else if (kind < 80) ts = {$urandom, $urandom};
        else if (kind < 90) ts = ts_now + 64'($urandom_range(140000)) - 64'd70000;
        else ts = $urandom_range(1) ? '1 : '0;
        if (cmd == CMD_ADD) ts_last = ts;
        send_command(cmd, ts, ($urandom_range(3) == 0), 1'($urandom), 16'($urandom));
      end
    end
    cmd_valid <= 1'b0;

    repeat (2) @(posedge clk);
    wait (responses_due == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("timestamp_ordered_frame_queue regression: pass");
    end else begin
      $display("timestamp_ordered_frame_queue regression: fail");
    end
    $finish;
  end

endmodule
